[src/pcpg_pkg.sv]
// pcpg_pkg: shared types and constants for the plain-changes permutation generator
// used by pcpg_cell, pcpg_pick and plain_changes_permutation_generator_core
// no dependencies
package pcpg_pkg;

   localparam int ELEM_W  = 4;
   localparam int COUNT_W = 5;
   localparam int PERM_W  = 64;

   // element count after reset
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MIN   = 5'd2;

   typedef logic [ELEM_W-1:0]  elem_type;
   typedef logic [COUNT_W-1:0] count_type;

   // what one cell shows its neighbours: element held and its direction
   typedef struct packed {
      elem_type elem;
      logic     dir_left;
   } cell_view_type;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic      clear;       // return to identity now
      logic      start;       // transaction begins from identity
      logic      step;        // transaction accepted, commit the swap
      logic      any_mobile;  // some element can move
      elem_type  mover;       // largest mobile element
      count_type count;       // active element count, clamped
   } cell_ctrl_type;

endpackage

[src/plain_changes_permutation_generator_core.sv]
// plain_changes_permutation_generator_core: top level of the plain-changes generator
// depends on pcpg_pkg, pcpg_cell and pcpg_pick
//
// Usage:
//   Each transaction on the req_ channel (req_valid high, req_stall low) makes the
//   block return one rsp_ transaction: the current permutation, four bits per
//   position (positions at or above the element count read as zero), the left
//   position of the pair swapped to reach it, and a last flag when no element can
//   move. The state then advances by one adjacent swap. req_restart forces the
//   identity first; the transaction after a last one also starts from identity.
//   csr_wr_en writes the element count (clamped to 2..MAX_ELEMENTS) and returns the
//   state to identity; write it only while no transaction is in flight.
//   rsp_valid rises in the cycle after acceptance. Throughput is one transaction
//   per clock while rsp_stall does not hold a waiting result; the mobility check,
//   largest-mover pick and swap across the row of position cells are combinational.
//   Reset gives an element count of 16, the identity permutation with every
//   element pointing left, and an empty output register.
//   While rsp_stall holds a waiting result, req_stall rises and the result holds.
module plain_changes_permutation_generator_core #(
   parameter int MAX_ELEMENTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pcpg_pkg::PERM_W-1:0]   rsp_permutation,
   output logic [pcpg_pkg::ELEM_W-1:0]   rsp_swap_position,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [pcpg_pkg::COUNT_W-1:0]  csr_wr_data
);

   localparam pcpg_pkg::count_type COUNT_MAX = pcpg_pkg::COUNT_W'(MAX_ELEMENTS);

   pcpg_pkg::count_type     count_ff;
   pcpg_pkg::count_type     count_active;
   logic                    done_ff;
   logic                    done_in;
   pcpg_pkg::elem_type      last_swap_ff;
   pcpg_pkg::elem_type      last_swap_in;
   logic                    accept;
   logic                    start;
   pcpg_pkg::cell_ctrl_type ctrl;
   pcpg_pkg::cell_view_type view_w [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] mobile_w;
   logic [MAX_ELEMENTS-1:0] mover_w;
   logic [MAX_ELEMENTS-1:0] mobile_by_value;
   logic                    any_mobile;
   pcpg_pkg::elem_type      mover_value;
   pcpg_pkg::elem_type      swap_pos;
   logic [pcpg_pkg::PERM_W-1:0] packed_perm;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [pcpg_pkg::PERM_W-1:0] rsp_permutation_ff;
   pcpg_pkg::elem_type          rsp_swap_position_ff;
   logic                        rsp_last_ff;

   // handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign start     = req_restart || done_ff;

   // clamp the element count
   always_comb begin
      if (count_ff < pcpg_pkg::COUNT_MIN) begin
         count_active = pcpg_pkg::COUNT_MIN;
      end else if (count_ff > COUNT_MAX) begin
         count_active = COUNT_MAX;
      end else begin
         count_active = count_ff;
      end
   end

   // control broadcast to the cells
   always_comb begin
      ctrl.clear      = csr_wr_en;
      ctrl.start      = start;
      ctrl.step       = accept && !csr_wr_en;
      ctrl.any_mobile = any_mobile;
      ctrl.mover      = mover_value;
      ctrl.count      = count_active;
   end

   // row of position cells
   for (genvar p = 0; p < MAX_ELEMENTS; p++) begin : g_cell
      pcpg_pkg::cell_view_type left_view;
      pcpg_pkg::cell_view_type right_view;
      logic                    left_mover;
      logic                    right_mover;

      if (p == 0) begin : g_left_edge
         assign left_view  = '0;
         assign left_mover = 1'b0;
      end else begin : g_left_link
         assign left_view  = view_w[p-1];
         assign left_mover = mover_w[p-1];
      end

      if (p == MAX_ELEMENTS - 1) begin : g_right_edge
         assign right_view  = '0;
         assign right_mover = 1'b0;
      end else begin : g_right_link
         assign right_view  = view_w[p+1];
         assign right_mover = mover_w[p+1];
      end

      pcpg_cell #(
         .POS(p)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_view   (left_view),
         .left_mover  (left_mover),
         .right_view  (right_view),
         .right_mover (right_mover),
         .own_view    (view_w[p]),
         .own_mobile  (mobile_w[p]),
         .own_mover   (mover_w[p])
      );
   end

   // mobile flags regrouped by element value
   always_comb begin
      mobile_by_value = '0;
      for (int p = 0; p < MAX_ELEMENTS; p++) begin
         for (int v = 0; v < MAX_ELEMENTS; v++) begin
            if (mobile_w[p] && (view_w[p].elem == pcpg_pkg::ELEM_W'(v))) begin
               mobile_by_value[v] = 1'b1;
            end
         end
      end
   end

   pcpg_pick #(
      .WIDTH(MAX_ELEMENTS)
   ) u_pick (
      .flags   (mobile_by_value),
      .any_set (any_mobile),
      .index   (mover_value)
   );

   // left position of the pair being swapped
   always_comb begin
      swap_pos = '0;
      for (int p = 0; p < MAX_ELEMENTS; p++) begin
         if (mover_w[p]) begin
            swap_pos = pcpg_pkg::ELEM_W'(p) - pcpg_pkg::ELEM_W'(view_w[p].dir_left);
         end
      end
   end

   // pack the current permutation
   always_comb begin
      packed_perm = '0;
      for (int p = 0; p < MAX_ELEMENTS; p++) begin
         if (pcpg_pkg::COUNT_W'(p) < count_active) begin
            packed_perm[pcpg_pkg::ELEM_W*p +: pcpg_pkg::ELEM_W] = view_w[p].elem;
         end
      end
   end

   // sequence state next values
   always_comb begin
      done_in      = done_ff;
      last_swap_in = last_swap_ff;
      if (accept) begin
         done_in = !any_mobile;
         if (any_mobile) begin
            last_swap_in = swap_pos;
         end else if (start) begin
            last_swap_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= pcpg_pkg::COUNT_RESET;
         done_ff      <= 1'b0;
         last_swap_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff     <= csr_wr_data;
         done_ff      <= 1'b0;
         last_swap_ff <= '0;
      end else begin
         done_ff      <= done_in;
         last_swap_ff <= last_swap_in;
      end
   end

   // output register
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_permutation_ff   <= packed_perm;
         rsp_swap_position_ff <= start ? '0 : last_swap_ff;
         rsp_last_ff          <= !any_mobile;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_permutation   = rsp_permutation_ff;
   assign rsp_swap_position = rsp_swap_position_ff;
   assign rsp_last          = rsp_last_ff;

   // checks
   a_one_mover : assert property (@(posedge clock) disable iff (reset)
      $onehot0(mover_w))
      else $error("more than one cell claims to be the mover");

   a_stall_needs_result : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

   a_restart_swap_zero : assert property (@(posedge clock) disable iff (reset)
      (accept && req_restart) |=> (rsp_valid && rsp_swap_position == '0))
      else $error("restarted transaction did not report swap position zero");

   a_last_marks_done : assert property (@(posedge clock) disable iff (reset)
      (accept && !any_mobile && !csr_wr_en) |=> (done_ff && rsp_last))
      else $error("final permutation not flagged or sequence not closed");

endmodule

[src/pcpg_cell.sv]
// pcpg_cell: one position of the permutation, holding its element and direction
// depends on pcpg_pkg
module pcpg_cell #(
   parameter int POS = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pcpg_pkg::cell_ctrl_type  ctrl,
   input  pcpg_pkg::cell_view_type  left_view,
   input  logic                     left_mover,
   input  pcpg_pkg::cell_view_type  right_view,
   input  logic                     right_mover,
   output pcpg_pkg::cell_view_type  own_view,
   output logic                     own_mobile,
   output logic                     own_mover
);

   localparam logic                       HAS_LEFT = (POS > 0);
   localparam logic [pcpg_pkg::COUNT_W-1:0] POS_IDX  = pcpg_pkg::COUNT_W'(POS);
   localparam logic [pcpg_pkg::COUNT_W-1:0] POS_NEXT = pcpg_pkg::COUNT_W'(POS + 1);
   localparam pcpg_pkg::elem_type           ID_ELEM  = pcpg_pkg::ELEM_W'(POS);

   pcpg_pkg::cell_view_type view_ff;
   pcpg_pkg::cell_view_type view_in;
   pcpg_pkg::cell_view_type moved;
   logic                    active;
   logic                    flip;

   // effective contents: identity when the transaction starts a sequence
   always_comb begin
      if (ctrl.start) begin
         own_view.elem     = ID_ELEM;
         own_view.dir_left = 1'b1;
      end else begin
         own_view = view_ff;
      end
   end

   // mobility against the neighbour in this element's direction
   assign active = (POS_IDX < ctrl.count);
   always_comb begin
      if (own_view.dir_left) begin
         own_mobile = active && HAS_LEFT && (left_view.elem < own_view.elem);
      end else begin
         own_mobile = active && (POS_NEXT < ctrl.count) && (right_view.elem < own_view.elem);
      end
   end

   assign own_mover = ctrl.any_mobile && (own_view.elem == ctrl.mover);

   // adjacent swap: take the neighbour's contents when either side of the pair moves
   always_comb begin
      moved = own_view;
      if (own_mover) begin
         moved = own_view.dir_left ? left_view : right_view;
      end else if (right_mover && right_view.dir_left) begin
         moved = right_view;
      end else if (left_mover && !left_view.dir_left) begin
         moved = left_view;
      end
   end

   // every active element larger than the mover turns round
   assign flip = ctrl.any_mobile && (moved.elem > ctrl.mover)
                 && ({1'b0, moved.elem} < ctrl.count);

   always_comb begin
      view_in.elem     = moved.elem;
      view_in.dir_left = moved.dir_left ^ flip;
   end

   // cell state
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         view_ff.elem     <= ID_ELEM;
         view_ff.dir_left <= 1'b1;
      end else if (ctrl.step) begin
         view_ff <= view_in;
      end
   end

endmodule

[src/pcpg_pick.sv]
// pcpg_pick: priority pick of the largest element value with its mobile flag set
// depends on pcpg_pkg
module pcpg_pick #(
   parameter int WIDTH = 16
) (
   input  logic [WIDTH-1:0]   flags,
   output logic               any_set,
   output pcpg_pkg::elem_type index
);

   // highest set flag wins
   always_comb begin
      any_set = |flags;
      index   = '0;
      for (int i = 0; i < WIDTH; i++) begin
         if (flags[i]) begin
            index = pcpg_pkg::ELEM_W'(i);
         end
      end
   end

endmodule
